// ===== rtl/ccpa_pkg.sv =====
// shared types and constants for the color contrast push-away block
package ccpa_pkg;

    localparam int FieldWidth = 13;
    localparam int FieldMax   = 8191;
    localparam int DistWidth  = 14;

    localparam logic [FieldWidth-1:0] MinDistReset = 13'd410;

    // configuration register index
    typedef enum logic [0:0] {
        REG_MIN_DISTANCE = 1'b0
    } reg_index_t;

    // result fields held in the output register
    typedef struct packed {
        logic [FieldWidth-1:0] out_red;
        logic [FieldWidth-1:0] out_green;
        logic [FieldWidth-1:0] out_blue;
        logic [FieldWidth-1:0] weighted_distance;
        logic                  pushed;
    } result_t;

endpackage

// ===== rtl/ccpa_sqrt_cell.sv =====
// one digit step of a restoring square root, registered, with payload carried along
module ccpa_sqrt_cell #(
    parameter int RadWidth = 64,
    parameter int ResWidth = 32,
    parameter int StepIdx  = 0,
    parameter int PayWidth = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RadWidth-1:0] in_rem,
    input  logic [ResWidth-1:0] in_root,
    input  logic [PayWidth-1:0] in_pay,
    output logic                out_valid,
    output logic [RadWidth-1:0] out_rem,
    output logic [ResWidth-1:0] out_root,
    output logic [PayWidth-1:0] out_pay
);
    localparam int BitPos = ResWidth - 1 - StepIdx;

    logic [RadWidth-1:0] trial;
    logic [RadWidth-1:0] rem_next;
    logic [ResWidth-1:0] root_next;
    logic                valid_reg;
    logic [RadWidth-1:0] rem_reg;
    logic [ResWidth-1:0] root_reg;
    logic [PayWidth-1:0] pay_reg;

    // try (root + bit)^2 = root^2 + 2*root*bit + bit^2
    always_comb begin
        trial = ((RadWidth'(in_root) << 1) + (RadWidth'(1) << BitPos)) << BitPos;
        if (in_rem >= trial) begin
            rem_next  = in_rem - trial;
            root_next = in_root | (ResWidth'(1) << BitPos);
        end else begin
            rem_next  = in_rem;
            root_next = in_root;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_pay   = pay_reg;
endmodule

// ===== rtl/ccpa_sqrt_chain.sv =====
// row of square root cells, one result bit per cell
module ccpa_sqrt_chain #(
    parameter int RadWidth = 64,
    parameter int ResWidth = 32,
    parameter int PayWidth = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RadWidth-1:0] in_rad,
    input  logic [PayWidth-1:0] in_pay,
    output logic                out_valid,
    output logic [ResWidth-1:0] out_root,
    output logic [PayWidth-1:0] out_pay
);
    logic                valid_w [ResWidth+1];
    logic [RadWidth-1:0] rem_w   [ResWidth+1];
    logic [ResWidth-1:0] root_w  [ResWidth+1];
    logic [PayWidth-1:0] pay_w   [ResWidth+1];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = in_rad;
    assign root_w[0]  = '0;
    assign pay_w[0]   = in_pay;

    // cells hand remainder and partial root to the next neighbor
    for (genvar k = 0; k < ResWidth; k++) begin : g_cell
        ccpa_sqrt_cell #(
            .RadWidth(RadWidth), .ResWidth(ResWidth), .StepIdx(k), .PayWidth(PayWidth)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(valid_w[k]), .in_rem(rem_w[k]), .in_root(root_w[k]),
            .in_pay(pay_w[k]),
            .out_valid(valid_w[k+1]), .out_rem(rem_w[k+1]), .out_root(root_w[k+1]),
            .out_pay(pay_w[k+1])
        );
    end

    assign out_valid = valid_w[ResWidth];
    assign out_root  = root_w[ResWidth];
    assign out_pay   = pay_w[ResWidth];
endmodule

// ===== rtl/ccpa_div_cell.sv =====
// one quotient bit step of a restoring divider, registered, payload carried along
module ccpa_div_cell #(
    parameter int NumWidth = 32,
    parameter int DenWidth = 16,
    parameter int StepIdx  = 0,
    parameter int PayWidth = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NumWidth-1:0] in_rem,
    input  logic [NumWidth-1:0] in_quo,
    input  logic [DenWidth-1:0] in_den,
    input  logic [PayWidth-1:0] in_pay,
    output logic                out_valid,
    output logic [NumWidth-1:0] out_rem,
    output logic [NumWidth-1:0] out_quo,
    output logic [DenWidth-1:0] out_den,
    output logic [PayWidth-1:0] out_pay
);
    localparam int BitPos = NumWidth - 1 - StepIdx;
    localparam int WideW  = NumWidth + DenWidth;

    logic [WideW-1:0]    shifted;
    logic [NumWidth-1:0] rem_next;
    logic [NumWidth-1:0] quo_next;
    logic                valid_reg;
    logic [NumWidth-1:0] rem_reg;
    logic [NumWidth-1:0] quo_reg;
    logic [DenWidth-1:0] den_reg;
    logic [PayWidth-1:0] pay_reg;

    // subtract den << bit when it fits
    always_comb begin
        shifted = WideW'(in_den) << BitPos;
        if (WideW'(in_rem) >= shifted) begin
            rem_next = in_rem - shifted[NumWidth-1:0];
            quo_next = in_quo | (NumWidth'(1) << BitPos);
        end else begin
            rem_next = in_rem;
            quo_next = in_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= in_den;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_pay   = pay_reg;
endmodule

// ===== rtl/ccpa_div_chain.sv =====
// row of divider cells for the three channel offsets, one quotient bit per cell
module ccpa_div_chain #(
    parameter int NumWidth = 32,
    parameter int DenWidth = 16,
    parameter int PayWidth = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [3*NumWidth-1:0] in_num,   // red, green, blue numerators
    input  logic [DenWidth-1:0]   in_den,
    input  logic [PayWidth-1:0]   in_pay,
    output logic                  out_valid,
    output logic [3*NumWidth-1:0] out_quo,  // red, green, blue quotients
    output logic [PayWidth-1:0]   out_pay
);
    localparam int LanePay = PayWidth;

    logic                  valid_w [NumWidth+1];
    logic [3*NumWidth-1:0] rem_w   [NumWidth+1];
    logic [3*NumWidth-1:0] quo_w   [NumWidth+1];
    logic [DenWidth-1:0]   den_w   [NumWidth+1];
    logic [LanePay-1:0]    pay_w   [NumWidth+1];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = in_num;
    assign quo_w[0]   = '0;
    assign den_w[0]   = in_den;
    assign pay_w[0]   = in_pay;

    // lane 0 carries the payload and valid, lanes 1 and 2 share its timing
    for (genvar k = 0; k < NumWidth; k++) begin : g_step
        ccpa_div_cell #(
            .NumWidth(NumWidth), .DenWidth(DenWidth), .StepIdx(k), .PayWidth(LanePay)
        ) u_lane0 (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(valid_w[k]),
            .in_rem(rem_w[k][NumWidth-1:0]), .in_quo(quo_w[k][NumWidth-1:0]),
            .in_den(den_w[k]), .in_pay(pay_w[k]),
            .out_valid(valid_w[k+1]), .out_rem(rem_w[k+1][NumWidth-1:0]),
            .out_quo(quo_w[k+1][NumWidth-1:0]), .out_den(den_w[k+1]),
            .out_pay(pay_w[k+1])
        );
        for (genvar l = 1; l < 3; l++) begin : g_lane
            logic          unused_valid;
            logic [DenWidth-1:0] unused_den;
            logic          unused_pay;
            ccpa_div_cell #(
                .NumWidth(NumWidth), .DenWidth(DenWidth), .StepIdx(k), .PayWidth(1)
            ) u_lane (
                .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(valid_w[k]),
                .in_rem(rem_w[k][l*NumWidth +: NumWidth]),
                .in_quo(quo_w[k][l*NumWidth +: NumWidth]),
                .in_den(den_w[k]), .in_pay(1'b0),
                .out_valid(unused_valid), .out_rem(rem_w[k+1][l*NumWidth +: NumWidth]),
                .out_quo(quo_w[k+1][l*NumWidth +: NumWidth]), .out_den(unused_den),
                .out_pay(unused_pay)
            );
        end
    end

    assign out_valid = valid_w[NumWidth];
    assign out_quo   = quo_w[NumWidth];
    assign out_pay   = pay_w[NumWidth];
endmodule

// ===== rtl/color_contrast_push_away_unit.sv =====
// top level of the color contrast push-away block
// Takes one color/reference pair per clock on the s_ stream and returns one result per pair
// on the m_ stream, in order. The pipeline holds 2 setup stages, 17 square root cells for the
// weighted distance, 1 stage for the divide by three and the direction set-up, 19 square root
// cells for the direction length, 1 product stage, 33 divider cells and 1 clamp stage.
// The whole row advances together and stalls only while a result waits on m_tready, so the
// sustained rate is one pair per cycle. min_distance is sampled when a pair enters, and should
// only be written while the block is empty.
module color_contrast_push_away_unit #(
    parameter int FRACTION_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // color_red, color_green, color_blue, ref_red, ref_green, ref_blue (13 bits each)
    input  logic [79:0] s_tdata,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red, out_green, out_blue, weighted_distance (13 bits each), pushed
    output logic [55:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int FW     = ccpa_pkg::FieldWidth;
    localparam int One    = 1 << FRACTION_BITS;
    localparam int ClampMax = (One > ccpa_pkg::FieldMax) ? ccpa_pkg::FieldMax : One;
    localparam int DW     = FW + 1;                  // signed difference
    localparam int SqW    = 2 * DW;                  // square of a difference
    localparam int TW     = SqW + FRACTION_BITS + 6; // weighted sum
    localparam int RadW   = TW - FRACTION_BITS - 1;
    localparam int RootW  = (RadW + 1) / 2;
    localparam int SumW   = SqW + 2;
    localparam int LenRadW = SumW + 8;
    localparam int LenW   = (LenRadW + 1) / 2;
    localparam int NumW   = FW + 1 + FW + 6;         // push times |16*d|
    localparam int OutW   = 3 * FW + FW + 1;

    // ---------------- configuration ----------------
    logic [FW-1:0] min_dist_reg;
    logic          cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
        (paddr == {ccpa_pkg::REG_MIN_DISTANCE, 1'b0} && 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg <= ccpa_pkg::MinDistReset;
        end else if (cfg_wr) begin
            min_dist_reg <= pwdata[FW-1:0];
        end
    end
    assign prdata = (paddr == {ccpa_pkg::REG_MIN_DISTANCE, 1'b0}) ?
        32'(min_dist_reg) : 32'd0;

    // ---------------- pipeline enable ----------------
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: differences and squares ----------------
    logic [FW-1:0] c_in [3];
    logic [FW-1:0] r_in [3];
    logic signed [SqW-1:0] dx [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_in[i] = s_tdata[i*FW +: FW];
            r_in[i] = s_tdata[(i+3)*FW +: FW];
            dx[i]   = SqW'($signed({1'b0, c_in[i]}) - $signed({1'b0, r_in[i]}));
        end
    end

    logic              v1_reg;
    logic signed [DW-1:0] d1_reg [3];
    logic [SqW-1:0]    sq1_reg [3];
    logic [FW:0]       s1_reg;
    logic [FW-1:0]     c1_reg [3];
    logic [FW-1:0]     md1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]  <= DW'(dx[i]);
                sq1_reg[i] <= SqW'(dx[i] * dx[i]);
                c1_reg[i]  <= c_in[i];
            end
            s1_reg  <= (FW+1)'(c_in[0]) + (FW+1)'(r_in[0]);
            md1_reg <= min_dist_reg;
        end
    end

    // ---------------- stage 2: weighted sum ----------------
    logic signed [TW+1:0] t_full;
    logic [SumW-1:0]      sqsum;
    always_comb begin
        t_full = $signed((TW+2)'(4*One) + (TW+2)'(s1_reg)) * $signed((TW+2)'(sq1_reg[0]))
               + $signed((TW+2)'(8*One)) * $signed((TW+2)'(sq1_reg[1]))
               + ($signed((TW+2)'(6*One)) - $signed((TW+2)'(s1_reg)))
                 * $signed((TW+2)'(sq1_reg[2]));
        sqsum  = SumW'(sq1_reg[0]) + SumW'(sq1_reg[1]) + SumW'(sq1_reg[2]);
    end

    // payload through the weighted distance root chain
    typedef struct packed {
        logic [3*DW-1:0]   d;
        logic [3*FW-1:0]   c;
        logic [FW-1:0]     md;
        logic [SumW-1:0]   sq;
    } pay_a_t;

    logic         v2_reg;
    logic [RadW-1:0] rad2_reg;
    pay_a_t       pa2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            rad2_reg <= t_full[TW+1] ? '0 : RadW'(t_full[TW-1:0] >> (FRACTION_BITS + 1));
            pa2_reg  <= '{d: {d1_reg[2], d1_reg[1], d1_reg[0]},
                          c: {c1_reg[2], c1_reg[1], c1_reg[0]},
                          md: md1_reg, sq: sqsum};
        end
    end

    // ---------------- weighted distance root chain ----------------
    logic             v3;
    logic [RootW-1:0] root3;
    pay_a_t           pa3;
    ccpa_sqrt_chain #(.RadWidth(RadW), .ResWidth(RootW), .PayWidth($bits(pay_a_t))) u_wroot (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2_reg), .in_rad(rad2_reg), .in_pay(pa2_reg),
        .out_valid(v3), .out_root(root3), .out_pay(pa3)
    );

    // ---------------- divide by three, decide, prepare direction ----------------
    // floor(x/3) by reciprocal multiply and one correction
    localparam int RecipW = RootW + 2;
    logic [RootW-1:0]   dist4;
    logic [2*RecipW+1:0] prod3;
    logic [RootW-1:0]   q3;
    always_comb begin
        prod3 = (2*RecipW+2)'(root3) * (2*RecipW+2)'(((1 << RecipW) + 2) / 3);
        q3    = RootW'(prod3 >> RecipW);
        if ((RootW+2)'(q3) * 3 > (RootW+2)'(root3)) q3 = q3 - 1'b1;
        else if ((RootW+2)'(q3) * 3 + 3 <= (RootW+2)'(root3)) q3 = q3 + 1'b1;
        dist4 = q3;
    end

    typedef struct packed {
        logic [3*DW-1:0] d;
        logic [3*FW-1:0] c;
        logic [FW-1:0]   wdist;
        logic [FW:0]     push;
        logic            pushed;
        logic            fallback;
    } pay_b_t;

    logic         v4_reg;
    pay_b_t       pb4_reg;
    logic [LenRadW-1:0] lrad4_reg;
    logic         is_push;
    logic         is_fb;
    always_comb begin
        is_push = RootW'(pa3.md) > dist4;
        is_fb   = (64'(pa3.sq) * 64'd1000000) < 64'(One) * 64'(One);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            pb4_reg.d        <= pa3.d;
            pb4_reg.c        <= pa3.c;
            pb4_reg.wdist    <= (dist4 > RootW'(ccpa_pkg::FieldMax)) ? FW'(ccpa_pkg::FieldMax)
                                                                     : FW'(dist4);
            pb4_reg.push     <= is_push ? (FW+1)'(pa3.md) - (FW+1)'(dist4) : '0;
            pb4_reg.pushed   <= is_push;
            pb4_reg.fallback <= is_fb;
            lrad4_reg        <= LenRadW'(pa3.sq) << 8;
        end
    end

    // ---------------- direction length root chain ----------------
    logic          v5;
    logic [LenW-1:0] len5;
    pay_b_t        pb5;
    ccpa_sqrt_chain #(.RadWidth(LenRadW), .ResWidth(LenW), .PayWidth($bits(pay_b_t))) u_lroot (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v4_reg), .in_rad(lrad4_reg), .in_pay(pb4_reg),
        .out_valid(v5), .out_root(len5), .out_pay(pb5)
    );

    // ---------------- numerators ----------------
    typedef struct packed {
        logic [2:0]      neg;
        logic [3*FW-1:0] c;
        logic [FW-1:0]   wdist;
        logic            pushed;
    } pay_c_t;

    logic            v6_reg;
    logic [3*NumW-1:0] num6_reg;
    logic [LenW-1:0] den6_reg;
    pay_c_t          pc6_reg;
    logic signed [DW-1:0] dl [3];
    logic [DW-1:0]   mag [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dl[i]  = pb5.d[i*DW +: DW];
            mag[i] = dl[i][DW-1] ? DW'(-dl[i]) : DW'(dl[i]);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (en)  v6_reg <= v5;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (pb5.fallback) begin
                num6_reg <= {NumW'(pb5.push), NumW'(pb5.push) << 1, NumW'(pb5.push) << 1};
                den6_reg <= LenW'(3);
                pc6_reg.neg <= 3'b010;
            end else begin
                num6_reg <= {NumW'(NumW'(pb5.push) * NumW'(mag[2])) << 4,
                             NumW'(NumW'(pb5.push) * NumW'(mag[1])) << 4,
                             NumW'(NumW'(pb5.push) * NumW'(mag[0])) << 4};
                den6_reg <= (len5 == '0) ? LenW'(1) : len5;
                pc6_reg.neg <= {dl[2][DW-1], dl[1][DW-1], dl[0][DW-1]};
            end
            pc6_reg.c      <= pb5.c;
            pc6_reg.wdist  <= pb5.wdist;
            pc6_reg.pushed <= pb5.pushed;
        end
    end

    // ---------------- offset divider chain ----------------
    logic            v7;
    logic [3*NumW-1:0] quo7;
    pay_c_t          pc7;
    ccpa_div_chain #(.NumWidth(NumW), .DenWidth(LenW), .PayWidth($bits(pay_c_t))) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v6_reg), .in_num(num6_reg), .in_den(den6_reg), .in_pay(pc6_reg),
        .out_valid(v7), .out_quo(quo7), .out_pay(pc7)
    );

    // ---------------- apply offset, clamp, output register ----------------
    ccpa_pkg::result_t res_next;
    ccpa_pkg::result_t res_reg;
    logic signed [NumW+1:0] r_sum [3];
    logic [FW-1:0]          ch    [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ch[i] = pc7.c[i*FW +: FW];
            if (pc7.neg[i])
                r_sum[i] = $signed((NumW+2)'(ch[i]))
                         - $signed((NumW+2)'(quo7[i*NumW +: NumW]));
            else
                r_sum[i] = $signed((NumW+2)'(ch[i]))
                         + $signed((NumW+2)'(quo7[i*NumW +: NumW]));
            if (pc7.pushed) begin
                if (r_sum[i] < 0) ch[i] = '0;
                else if (r_sum[i] > ClampMax) ch[i] = FW'(ClampMax);
                else ch[i] = FW'(r_sum[i]);
            end
        end
        res_next = '{out_red: ch[0], out_green: ch[1], out_blue: ch[2],
                     weighted_distance: pc7.wdist, pushed: pc7.pushed};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (en)  out_valid_reg <= v7;
    end
    always_ff @(posedge aclk) begin
        if (en) res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(56 - OutW)'(0), res_reg.pushed, res_reg.weighted_distance,
                       res_reg.out_blue, res_reg.out_green, res_reg.out_red};

    // ---------------- assertions ----------------
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_pushed_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.pushed |-> res_reg.out_red <= ClampMax &&
        res_reg.out_green <= ClampMax && res_reg.out_blue <= ClampMax)
        else $error("pushed channel outside clamp range");
endmodule
